[src/hrc_pkg.sv]
package hrc_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int ADDR_BITS      = 4;
  localparam int GAIN_W         = 16;
  localparam int SPEED_W        = 24;
  localparam int GAIN_GROW      = 333;

  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 16'd128;
  localparam logic [GAIN_W-1:0]  GAIN_NEAR_POS = 16'd512;
  localparam logic [GAIN_W-1:0]  GAIN_NEAR_NEG = 16'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_MAX      = 16'hFFFF;
  localparam logic [SPEED_W-1:0] SPEED_MAX     = 24'h7FFFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN     = 24'h800000;

  localparam logic signed [15:0] GOAL_RESET   = 16'sd0;
  localparam logic [14:0]        DEAD_RESET   = 15'd521;
  localparam logic [14:0]        NEAR_RESET   = 15'd1043;
  localparam logic [15:0]        SETTLE_RESET = 16'd300;

  typedef enum logic [1:0] {
    REG_GOAL   = 2'd0,
    REG_DEAD   = 2'd1,
    REG_NEAR   = 2'd2,
    REG_SETTLE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_TURN  = 2'd0,
    ST_HOLD  = 2'd1,
    ST_DONE  = 2'd2,
    ST_PAUSE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_DECIDE,
    S_GROW,
    S_GSAT,
    S_MUL,
    S_SPD
  } seq_state_t;

  typedef struct packed {
    logic signed [15:0] goal_heading;
    logic [14:0]        dead_band;
    logic [14:0]        near_band;
    logic [15:0]        settle_ms;
  } hrc_cfg_t;

endpackage

[src/hrc_if.sv]
interface hrc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_yaw;
  logic [31:0]        timestamp_ms;
  logic               paused;
  logic               restart;

  modport source (output valid, measured_yaw, timestamp_ms, paused, restart, input ready);
  modport sink (input valid, measured_yaw, timestamp_ms, paused, restart, output ready);
endinterface

interface hrc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] speed;
  logic [1:0]         status;

  modport source (output valid, speed, status, input ready);
  modport sink (input valid, speed, status, output ready);
endinterface

[src/hrc_regs.sv]
module hrc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output hrc_pkg::hrc_cfg_t              cfg
);

  hrc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx = hrc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_heading <= hrc_pkg::GOAL_RESET;
      cfg.dead_band    <= hrc_pkg::DEAD_RESET;
      cfg.near_band    <= hrc_pkg::NEAR_RESET;
      cfg.settle_ms    <= hrc_pkg::SETTLE_RESET;
    end else if (wr) begin
      case (idx)
        hrc_pkg::REG_GOAL:   cfg.goal_heading <= signed'(pwdata[15:0]);
        hrc_pkg::REG_DEAD:   cfg.dead_band    <= pwdata[14:0];
        hrc_pkg::REG_NEAR:   cfg.near_band    <= pwdata[14:0];
        hrc_pkg::REG_SETTLE: cfg.settle_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hrc_pkg::REG_GOAL:   prdata = {16'b0, cfg.goal_heading};
      hrc_pkg::REG_DEAD:   prdata = {17'b0, cfg.dead_band};
      hrc_pkg::REG_NEAR:   prdata = {17'b0, cfg.near_band};
      hrc_pkg::REG_SETTLE: prdata = {16'b0, cfg.settle_ms};
      default:             prdata = 32'b0;
    endcase
  end

endmodule

[src/hrc_mul.sv]
module hrc_mul #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[src/hrc_seq.sv]
module hrc_seq #(
  parameter int ANGLE_BITS = hrc_pkg::ANGLE_BITS_DEF,
  parameter int BW         = (ANGLE_BITS > 10) ? ANGLE_BITS : 10,
  parameter int PW         = 17 + BW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hrc_pkg::hrc_cfg_t    cfg,
  hrc_in_if.sink               tick,
  hrc_out_if.source            result,
  output logic signed [16:0]   mul_a,
  output logic signed [BW-1:0] mul_b,
  input  logic signed [PW-1:0] mul_p
);

  localparam int DW = (ANGLE_BITS > 17) ? ANGLE_BITS : 17;
  localparam int CW = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 1;
  localparam int SW = ((PW - 8) > 24) ? (PW - 8) : 24;

  hrc_pkg::seq_state_t state, state_next;

  logic signed [15:0]           yaw_q;
  logic [31:0]                  now_q;
  logic                         paused_q;
  logic signed [ANGLE_BITS-1:0] err_q;
  logic [31:0]                  arm_q;
  logic signed [ANGLE_BITS-1:0] last_error;
  logic                         have_last;
  logic [15:0]                  gain;
  logic [31:0]                  deadline;
  logic                         finished;
  logic                         out_valid;
  logic signed [23:0]           speed_q;
  logic [1:0]                   status_q;

  logic signed [DW-1:0]         diff;
  logic signed [CW-1:0]         err_x;
  logic [CW-1:0]                mag;
  logic                         out_band;
  logic                         near;
  logic signed [ANGLE_BITS-1:0] last_eff;
  logic                         same;
  logic [31:0]                  dl_eff;
  logic [31:0]                  d;
  logic                         passed;
  logic                         out_free;
  logic                         quiet;
  logic                         decide_fire;
  logic [PW-9:0]                gw;
  logic [15:0]                  gain_sat;
  logic signed [PW-9:0]         sh;
  logic signed [SW-1:0]         sh_ext;
  logic [SW-24:0]               hi;
  logic [23:0]                  spd_sat;

  assign diff     = DW'(cfg.goal_heading) - DW'(yaw_q);
  assign err_x    = CW'(err_q);
  assign mag      = err_x[CW-1] ? CW'(-err_x) : CW'(err_x);
  assign out_band = mag > CW'(cfg.dead_band);
  assign near     = mag < CW'(cfg.near_band);
  assign last_eff = have_last ? last_error : err_q;
  assign same     = last_eff == err_q;
  assign dl_eff   = have_last ? deadline : arm_q;
  assign d        = now_q - dl_eff;
  assign passed   = (d != 32'd0) && !d[31];
  assign out_free = !out_valid || result.ready;
  assign quiet    = finished || paused_q || !out_band;
  assign decide_fire = (state == hrc_pkg::S_DECIDE) && (!quiet || out_free);

  assign gw       = mul_p[PW-1:8];
  assign gain_sat = (gw[PW-9:16] != '0) ? hrc_pkg::GAIN_MAX : gw[15:0];
  assign sh       = mul_p[PW-1:8];
  assign sh_ext   = SW'(sh);
  assign hi       = sh_ext[SW-1:23];
  assign spd_sat  = ((&hi) || (~|hi)) ? sh_ext[23:0] :
                    (sh_ext[SW-1] ? hrc_pkg::SPEED_MIN : hrc_pkg::SPEED_MAX);

  assign mul_a = signed'({1'b0, gain});
  assign mul_b = (state == hrc_pkg::S_GROW) ? BW'(hrc_pkg::GAIN_GROW) : BW'(err_q);

  assign tick.ready    = (state == hrc_pkg::S_IDLE);
  assign result.valid  = out_valid;
  assign result.speed  = speed_q;
  assign result.status = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hrc_pkg::S_IDLE:   if (tick.valid) state_next = hrc_pkg::S_ERR;
      hrc_pkg::S_ERR:    state_next = hrc_pkg::S_DECIDE;
      hrc_pkg::S_DECIDE: begin
        if (quiet) begin
          if (out_free) state_next = hrc_pkg::S_IDLE;
        end else if (same) begin
          state_next = hrc_pkg::S_GROW;
        end else begin
          state_next = hrc_pkg::S_MUL;
        end
      end
      hrc_pkg::S_GROW:   state_next = hrc_pkg::S_GSAT;
      hrc_pkg::S_GSAT:   state_next = hrc_pkg::S_MUL;
      hrc_pkg::S_MUL:    state_next = hrc_pkg::S_SPD;
      hrc_pkg::S_SPD:    if (out_free) state_next = hrc_pkg::S_IDLE;
      default:           state_next = hrc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == hrc_pkg::S_IDLE && tick.valid) begin
      yaw_q    <= tick.measured_yaw;
      now_q    <= tick.timestamp_ms;
      paused_q <= tick.paused;
    end
    if (state == hrc_pkg::S_ERR) begin
      err_q <= diff[ANGLE_BITS-1:0];
      arm_q <= now_q + 32'(cfg.settle_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      have_last  <= 1'b0;
      gain       <= hrc_pkg::GAIN_RESET;
      deadline   <= '0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
      speed_q    <= '0;
      status_q   <= hrc_pkg::ST_TURN;
    end else begin
      if (result.ready) out_valid <= 1'b0;

      if (state == hrc_pkg::S_IDLE && tick.valid && tick.restart) begin
        last_error <= '0;
        have_last  <= 1'b0;
        gain       <= hrc_pkg::GAIN_RESET;
        deadline   <= '0;
        finished   <= 1'b0;
      end

      if (decide_fire) begin
        if (finished) begin
          out_valid <= 1'b1;
          speed_q   <= '0;
          status_q  <= hrc_pkg::ST_DONE;
        end else if (paused_q) begin
          out_valid <= 1'b1;
          speed_q   <= '0;
          status_q  <= hrc_pkg::ST_PAUSE;
        end else begin
          last_error <= err_q;
          have_last  <= 1'b1;
          if (!have_last || out_band) deadline <= arm_q;
          if (out_band) begin
            if (same) begin
              if (!have_last) gain <= hrc_pkg::GAIN_RESET;
            end else if (near) begin
              gain <= err_q[ANGLE_BITS-1] ? hrc_pkg::GAIN_NEAR_NEG : hrc_pkg::GAIN_NEAR_POS;
            end else begin
              gain <= hrc_pkg::GAIN_RESET;
            end
          end else begin
            out_valid <= 1'b1;
            speed_q   <= '0;
            finished  <= passed && same;
            status_q  <= (passed && same) ? hrc_pkg::ST_DONE : hrc_pkg::ST_HOLD;
          end
        end
      end

      if (state == hrc_pkg::S_GSAT) gain <= gain_sat;

      if (state == hrc_pkg::S_SPD && out_free) begin
        out_valid <= 1'b1;
        speed_q   <= signed'(spd_sat);
        status_q  <= hrc_pkg::ST_TURN;
      end
    end
  end

endmodule

[src/heading_rotate_controller_top.sv]
// Heading rotate controller.
// Input channel tick: one control transaction per tick carrying measured_yaw,
// timestamp_ms, paused and restart. Output channel result: one transaction per
// tick with the speed command and a status code (turning, holding, done, paused).
// Configuration goes through the APB port: goal_heading at 0x0, dead_band at
// 0x4, near_band at 0x8, settle_ms at 0xC; write only while no tick is in flight.
// An accepted tick runs S_ERR and S_DECIDE and then returns to idle if the
// result needs no product (paused, done, in band), else runs S_MUL and S_SPD,
// after S_GROW and S_GSAT when the gain grows; one shared multiplier computes
// gain * 333 and gain * error in turn; the next tick is accepted only in idle.
// The result sits in an output register: the next tick is accepted while a
// result still waits, and the sequencer holds its final step while the receiver
// stalls with that register full.
// Reset (rst, synchronous) restores the register defaults and the kept control
// state (gain 0.5, no last error, deadline cleared, not finished).
module heading_rotate_controller_top #(
  parameter int ANGLE_BITS = hrc_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  hrc_in_if.sink                        tick,
  hrc_out_if.source                     result
);

  localparam int BW = (ANGLE_BITS > 10) ? ANGLE_BITS : 10;
  localparam int PW = 17 + BW;

  hrc_pkg::hrc_cfg_t    cfg;
  logic signed [16:0]   mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  assign pready = 1'b1;

  hrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hrc_mul #(
    .AW (17),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  hrc_seq #(
    .ANGLE_BITS (ANGLE_BITS),
    .BW         (BW),
    .PW         (PW)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .result (result),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .mul_p  (mul_p)
  );

endmodule

[bench/heading_rotate_controller_top_tb.sv]
module heading_rotate_controller_top_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int QUIET_CYCLES = 12;

  localparam logic [15:0] GAIN_START = 16'd128;
  localparam logic [15:0] GAIN_POS   = 16'd512;
  localparam logic [15:0] GAIN_NEG   = 16'd1024;
  localparam logic [31:0] GROW_MUL   = 32'd333;

  typedef struct packed {
    logic signed [23:0] speed;
    hrc_pkg::status_t   status;
  } heading_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hrc_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  hrc_in_if  tick_ch();
  hrc_out_if result_ch();

  heading_rotate_controller_top dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .tick   (tick_ch),
    .result (result_ch)
  );

  logic signed [15:0] aim_q      = 16'sd0;
  logic [14:0]        dead_q     = 15'd521;
  logic [14:0]        near_q     = 15'd1043;
  logic [15:0]        settle_q   = 16'd300;
  logic signed [15:0] prev_error = 16'sd0;
  logic               have_prev  = 1'b0;
  logic [15:0]        gain_q     = 16'd128;
  logic [31:0]        deadline_q = 32'd0;
  logic               settled    = 1'b0;

  heading_result_t pending_results[$];
  heading_result_t want;
  int              mismatch_count = 0;
  int              send_idle_pct  = 0;
  int              stall_pct      = 0;
  logic [31:0]     clock_ms       = 32'd0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  function automatic heading_result_t predict_heading(input logic signed [15:0] yaw,
      input logic [31:0] now, input logic paused, input logic restart);
    heading_result_t    r;
    logic signed [15:0] err;
    logic [31:0]        since;
    logic [31:0]        grown;
    longint             prod;
    longint             spd;
    int                 mag;
    logic               same;
    r.speed  = '0;
    r.status = hrc_pkg::ST_TURN;
    if (restart) begin
      prev_error = '0;
      have_prev  = 1'b0;
      gain_q     = GAIN_START;
      deadline_q = '0;
      settled    = 1'b0;
    end
    if (settled) begin
      r.status = hrc_pkg::ST_DONE;
      return r;
    end
    if (paused) begin
      r.status = hrc_pkg::ST_PAUSE;
      return r;
    end
    err = aim_q - yaw;
    if (!have_prev) begin
      prev_error = err;
      gain_q     = GAIN_START;
      deadline_q = now + 32'(settle_q);
    end
    same = (prev_error == err);
    mag  = (err < 0) ? -int'(err) : int'(err);
    if (mag > int'(dead_q)) begin
      if (same) begin
        grown  = (32'(gain_q) * GROW_MUL) >> 8;
        gain_q = (grown > 32'hFFFF) ? 16'hFFFF : grown[15:0];
      end else if (err > 0 && int'(err) < int'(near_q)) begin
        gain_q = GAIN_POS;
      end else if (err < 0 && int'(err) > -int'(near_q)) begin
        gain_q = GAIN_NEG;
      end else begin
        gain_q = GAIN_START;
      end
      prod = longint'(gain_q) * longint'(err);
      spd  = prod >>> 8;
      if (spd > 64'sd8388607) spd = 64'sd8388607;
      if (spd < -64'sd8388608) spd = -64'sd8388608;
      r.speed    = spd[23:0];
      deadline_q = now + 32'(settle_q);
      r.status   = hrc_pkg::ST_TURN;
    end else begin
      since = now - deadline_q;
      if (since != 0 && !since[31] && same) begin
        settled  = 1'b1;
        r.status = hrc_pkg::ST_DONE;
      end else begin
        r.status = hrc_pkg::ST_HOLD;
      end
    end
    prev_error = err;
    have_prev  = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction: speed %0d status %0d", $time,
                   result_ch.speed, result_ch.status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.speed !== result_ch.speed) begin
            $display("%0t: speed mismatch: expected %0d actual %0d", $time, want.speed,
                     result_ch.speed);
            mismatch_count++;
          end
          if (want.status !== result_ch.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                     result_ch.status);
            mismatch_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_tick(input logic signed [15:0] yaw, input logic [31:0] now,
      input logic paused, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.measured_yaw <= yaw;
    tick_ch.timestamp_ms <= now;
    tick_ch.paused       <= paused;
    tick_ch.restart      <= restart;
    do @(posedge clk); while (!tick_ch.ready);
    pending_results.push_back(predict_heading(yaw, now, paused, restart));
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input hrc_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      hrc_pkg::REG_GOAL:   aim_q    = value[15:0];
      hrc_pkg::REG_DEAD:   dead_q   = value[14:0];
      hrc_pkg::REG_NEAR:   near_q   = value[14:0];
      hrc_pkg::REG_SETTLE: settle_q = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_settle_after_reset();
    send_tick(16'sd0, 32'd1000, 1'b0, 1'b0);
    send_tick(16'sd0, 32'd1300, 1'b0, 1'b0);
    send_tick(16'sd0, 32'd1301, 1'b0, 1'b0);
    send_tick(16'sh7FFF, 32'd1302, 1'b1, 1'b0);
    send_tick(16'sd0, 32'd1303, 1'b1, 1'b1);
    send_tick(-16'sd600, 32'd1304, 1'b0, 1'b0);
    send_tick(-16'sd600, 32'd1305, 1'b0, 1'b0);
    send_tick(-16'sd1000, 32'd1306, 1'b0, 1'b0);
    send_tick(16'sd1000, 32'd1307, 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    drain_results();
    write_register(hrc_pkg::REG_GOAL, 32'h0000_7FFF);
    write_register(hrc_pkg::REG_DEAD, 32'd0);
    write_register(hrc_pkg::REG_NEAR, 32'h0000_7FFF);
    write_register(hrc_pkg::REG_SETTLE, 32'd0);
    send_tick(-16'sd32768, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_tick(16'sh7FFF, 32'h0000_0000, 1'b0, 1'b0);
    send_tick(16'sh7FFF, 32'h0000_0001, 1'b0, 1'b0);
    drain_results();
    write_register(hrc_pkg::REG_GOAL, 32'hFFFF_8000);
    send_tick(16'sd0, 32'h8000_0000, 1'b0, 1'b1);
    send_tick(16'sh7FFF, 32'h8000_0001, 1'b0, 1'b0);
    send_tick(16'sh8001, 32'h8000_0002, 1'b0, 1'b0);
    drain_results();
    write_register(hrc_pkg::REG_DEAD, 32'h0000_7FFF);
    send_tick(16'sd0, 32'h8000_0003, 1'b0, 1'b0);
    send_tick(16'sd1, 32'h8000_0004, 1'b0, 1'b0);
  endtask

  task automatic test_band_edges();
    drain_results();
    write_register(hrc_pkg::REG_GOAL, 32'd0);
    write_register(hrc_pkg::REG_DEAD, 32'd100);
    write_register(hrc_pkg::REG_NEAR, 32'd200);
    write_register(hrc_pkg::REG_SETTLE, 32'hFFFF);
    send_tick(-16'sd100, 32'd50, 1'b0, 1'b1);
    send_tick(-16'sd101, 32'd51, 1'b0, 1'b0);
    send_tick(16'sd199, 32'd52, 1'b0, 1'b0);
    send_tick(-16'sd200, 32'd53, 1'b0, 1'b0);
    send_tick(16'sd200, 32'd54, 1'b0, 1'b0);
    send_tick(16'sd200, 32'd55, 1'b0, 1'b0);
    send_tick(16'sd100, 32'd56, 1'b0, 1'b0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_in, input int n_ticks);
    int sent;
    int off;
    int r;
    int len;
    int k;
    drain_results();
    write_register(hrc_pkg::REG_GOAL, $urandom);
    r = $urandom_range(9);
    write_register(hrc_pkg::REG_DEAD,
                   (r == 0) ? 32'd0 : (r == 1) ? 32'h7FFF : $urandom_range(0, 1500));
    r = $urandom_range(9);
    write_register(hrc_pkg::REG_NEAR,
                   (r == 0) ? 32'd0 : (r == 1) ? 32'h7FFF : $urandom_range(0, 3000));
    r = $urandom_range(9);
    write_register(hrc_pkg::REG_SETTLE,
                   (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF : $urandom_range(0, 400));
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    sent = 0;
    while (sent < n_ticks) begin
      off = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(9) == 0) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end else if ($urandom_range(9) == 0) begin
        clock_ms = $urandom;
      end
      send_tick(aim_q - off[15:0], clock_ms, $urandom_range(9) == 0, 1'b1);
      len = $urandom_range(5, 40);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 35) begin
        end else if (r < 70) begin
          off = off - off / int'($urandom_range(2, 4));
        end else if (r < 85) begin
          off = int'($urandom_range(0, 2 * int'(near_q) + 40)) - int'(near_q) - 20;
        end else begin
          off = int'($urandom_range(0, 65535)) - 32768;
        end
        clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom_range(0, 70000)
                                                         : $urandom_range(0, 80));
        send_tick(aim_q - off[15:0], clock_ms, $urandom_range(99) < 5,
                  $urandom_range(99) < 2);
      end
      sent += len + 1;
      if ($urandom_range(4) == 0) drain_results();
    end
  endtask

  initial begin
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.measured_yaw <= '0;
    tick_ch.timestamp_ms <= '0;
    tick_ch.paused       <= 1'b0;
    tick_ch.restart      <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_settle_after_reset();
    test_field_extremes();
    test_band_edges();
    test_random_phase(0, 0, 100);
    test_random_phase(78, 0, 100);
    test_random_phase(0, 78, 100);
    test_random_phase(22, 22, 100);
    drain_results();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
